// File: rtl/core/fpas_pkg.sv
// ---------------------------------------------------------------------------
// fpas_pkg
// Shared types and constants of the single-precision adder.
// ---------------------------------------------------------------------------
package fpas_pkg;
    localparam logic [7:0]  ExpMax = 8'hFF;

    typedef enum logic [0:0] {
        CMD_ADD = 1'b0,
        CMD_SUB = 1'b1
    } t_cmd;

    // Count of leading zeros of a 26-bit significand, 26 when all zero.
    function automatic logic [4:0] lead_shift(input logic [25:0] v);
        logic [4:0] n;
        logic       hit;
        n   = 5'd26;
        hit = 1'b0;
        for (int b = 25; b >= 0; b--) begin
            if (!hit && v[b]) begin
                n   = 5'(25 - b);
                hit = 1'b1;
            end
        end
        return n;
    endfunction
endpackage

// File: rtl/core/fp32_add_sub.sv
// ---------------------------------------------------------------------------
// fp32_add_sub
// Single-precision adder and subtracter on IEEE bit patterns.
// ---------------------------------------------------------------------------
// Usage: the input channel carries a command word (add or subtract) and two
// operands; the output channel carries the rounded 32-bit sum. Both use
// valid/ready. Subnormal inputs count as zero; exponent 255 is an ordinary
// number. Rounding is to nearest even with this unit's sticky rule.
// An accepted word passes through four register stages to the output, and one
// word is accepted every cycle while the receiver does not stall.
// The four stages are: unpack and align, add and carry handling,
// normalize, round and pack.
// When the receiver stalls, every stage holds its word and the input ready
// drops only once the pipeline is full; no word is lost or repeated.
// Reset clears the valid bits of all stages; data registers are not reset.
// ---------------------------------------------------------------------------
module fp32_add_sub
    import fpas_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_cmd,
    input  logic [31:0] i_operand_a,
    input  logic [31:0] i_operand_b,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_sum
);
    // Stage valid bits and stage enables.
    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;
    assign en4 = !r_v4 || i_ready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_ready = en1;

    // ---------------- stage 1: unpack, select, align ----------------
    logic [31:0] b_eff;
    logic        sa, sb, sel;
    logic [7:0]  ea, eb, diff, es;
    logic [23:0] ma, mb, ms, mi;
    logic [4:0]  de;
    logic [54:0] mia;
    logic        n_stck1;
    always_comb begin
        b_eff = i_operand_b;
        if (t_cmd'(i_cmd) == CMD_SUB) b_eff[31] = ~b_eff[31];
        sa = i_operand_a[31];
        sb = b_eff[31];
        ea = i_operand_a[30:23];
        eb = b_eff[30:23];
        ma = (ea == '0) ? '0 : {1'b1, i_operand_a[22:0]};
        mb = (eb == '0) ? '0 : {1'b1, b_eff[22:0]};
        diff = (ea > eb) ? ea - eb : eb - ea;
        de = (diff > 8'd31) ? 5'd31 : diff[4:0];
        sel = (de == '0) ? !(ma > mb) : !(ea > eb);
        ms = sel ? mb : ma;
        mi = sel ? ma : mb;
        es = sel ? eb : ea;
        mia = {mi, 31'd0} >> de;
        n_stck1 = |mia[28:0];
    end

    logic        r1_sa, r1_sb, r1_ss, r1_stck;
    logic [7:0]  r1_es;
    logic [23:0] r1_ms;
    logic [25:0] r1_mi;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (en1) r_v1 <= i_valid;
        if (en1) begin
            r1_sa <= sa; r1_sb <= sb; r1_ss <= sel ? sb : sa;
            r1_es <= es; r1_ms <= ms; r1_mi <= mia[54:29]; r1_stck <= n_stck1;
        end
    end

    // ---------------- stage 2: add/subtract, carry ----------------
    logic        same2, n_stck2;
    logic [26:0] mye;
    logic [8:0]  esi, n_eyd;
    logic [25:0] n_myd;
    always_comb begin
        same2 = (r1_sa == r1_sb);
        mye = same2 ? {1'b0, r1_ms, 2'b00} + {1'b0, r1_mi}
                    : {1'b0, r1_ms, 2'b00} - {1'b0, r1_mi};
        esi = {1'b0, r1_es} + 9'd1;
        if (mye[26]) begin
            if (esi == {1'b0, ExpMax}) begin
                n_eyd = {1'b0, ExpMax}; n_myd = 26'h2000000; n_stck2 = 1'b0;
            end else begin
                n_eyd = esi; n_myd = mye[26:1]; n_stck2 = r1_stck | mye[0];
            end
        end else begin
            n_eyd = {1'b0, r1_es}; n_myd = mye[25:0]; n_stck2 = r1_stck;
        end
    end

    logic        r2_sa, r2_sb, r2_ss, r2_stck;
    logic [8:0]  r2_eyd;
    logic [25:0] r2_myd;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (en2) r_v2 <= r_v1;
        if (en2) begin
            r2_sa <= r1_sa; r2_sb <= r1_sb; r2_ss <= r1_ss; r2_stck <= n_stck2;
            r2_eyd <= n_eyd; r2_myd <= n_myd;
        end
    end

    // ---------------- stage 3: normalize ----------------
    logic [4:0]  se;
    logic signed [9:0] eyf;
    logic [8:0]  dm1;
    logic [7:0]  n_eyr;
    logic [25:0] n_myf;
    always_comb begin
        se = lead_shift(r2_myd);
        eyf = $signed({1'b0, r2_eyd}) - $signed({5'd0, se});
        dm1 = r2_eyd - 9'd1;
        if (eyf > 0) begin
            n_eyr = eyf[7:0];
            n_myf = r2_myd << se;
        end else begin
            // Result underflows: shift only as far as the exponent allows.
            n_eyr = '0;
            n_myf = r2_myd << dm1[4:0];
        end
    end

    logic        r3_sa, r3_sb, r3_ss, r3_stck;
    logic [7:0]  r3_eyr;
    logic [25:0] r3_myf;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else if (en3) r_v3 <= r_v2;
        if (en3) begin
            r3_sa <= r2_sa; r3_sb <= r2_sb; r3_ss <= r2_ss; r3_stck <= r2_stck;
            r3_eyr <= n_eyr; r3_myf <= n_myf;
        end
    end

    // ---------------- stage 4: round and pack ----------------
    logic        g, r, l, up, same4, sy;
    logic [24:0] myr;
    logic [8:0]  ey;
    logic [22:0] my;
    always_comb begin
        same4 = (r3_sa == r3_sb);
        g = r3_myf[1]; r = r3_myf[0]; l = r3_myf[2];
        up = (g && !r && !r3_stck && l) || (g && !r && same4 && r3_stck) || (g && r);
        myr = {1'b0, r3_myf[25:2]} + {24'd0, up};
        // The exponent keeps its ninth bit so that a rounding carry out of 255
        // is not taken for a zero result when the sign is chosen.
        if (myr[24]) begin
            ey = {1'b0, r3_eyr} + 9'd1; my = '0;
        end else if (myr[23:0] == '0) begin
            ey = '0; my = '0;
        end else begin
            ey = {1'b0, r3_eyr}; my = myr[22:0];
        end
        sy = (ey == '0 && my == '0) ? (r3_sa & r3_sb) : r3_ss;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v4 <= 1'b0;
        else if (en4) r_v4 <= r_v3;
        if (en4) o_sum <= {sy, ey[7:0], my};
    end
    assign o_valid = r_v4;

`ifndef ASSERT_OFF
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sum))
        else $error("output word changed under stall");
    a_full_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_v1 && r_v2 && r_v3 && r_v4 && !i_ready)
        else $error("input stalled while pipeline not full");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_v1)
        else $error("accepted word not captured");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");
`endif
endmodule
